// ===== rtl/core/llms_pkg.sv =====
// Shared constants, codes and command types for the layered LED matrix scanner.
package llms_pkg;

  localparam int ROWS  = 8;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  // Operation codes
  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_WRITE_ROW = 3'd1;
  localparam logic [2:0] OP_CLEAR     = 3'd2;
  localparam logic [2:0] OP_SET_TIMER = 3'd3;
  localparam logic [2:0] OP_POPUP     = 3'd4;

  // Layer codes
  localparam logic [1:0] LAYER_FRONT   = 2'd0;
  localparam logic [1:0] LAYER_BACK    = 2'd1;
  localparam logic [1:0] LAYER_OVERLAY = 2'd2;

  // Configuration register indexes
  localparam logic CFG_POPUP_DURATION   = 1'b0;
  localparam logic CFG_FOREGROUND_SLOTS = 1'b1;

  localparam logic [15:0] POPUP_DURATION_RST   = 16'd500;
  localparam logic [3:0]  FOREGROUND_SLOTS_RST = 4'd6;

  typedef struct packed {
    logic tick;
    logic write_row;
    logic clear_layer;
    logic set_timer;
    logic popup;
  } cmd_t;

endpackage

// ===== rtl/core/llms_ctrl.sv =====
// Controller: handshake state machine and operation decode for the scanner.
module llms_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        operation_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output llms_pkg::cmd_t    cmd_o
);

  localparam logic ST_EMPTY = 1'b0;
  localparam logic ST_FULL  = 1'b1;

  logic state_q, state_d;
  logic accept;

  // Output register frees up in the same cycle it is taken.
  assign in_ready_o  = (state_q == ST_EMPTY) || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == ST_FULL);

  always_comb begin
    cmd_o.tick        = accept && (operation_i == llms_pkg::OP_TICK);
    cmd_o.write_row   = accept && (operation_i == llms_pkg::OP_WRITE_ROW);
    cmd_o.clear_layer = accept && (operation_i == llms_pkg::OP_CLEAR);
    cmd_o.set_timer   = accept && (operation_i == llms_pkg::OP_SET_TIMER);
    cmd_o.popup       = accept && (operation_i == llms_pkg::OP_POPUP);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_EMPTY: begin
        if (cmd_o.tick) state_d = ST_FULL;
      end
      ST_FULL: begin
        if (out_ready_i) state_d = cmd_o.tick ? ST_FULL : ST_EMPTY;
      end
      default: state_d = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/llms_dp.sv =====
// Datapath: row stores, scan counters, overlay timer, config and output registers.
module llms_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  llms_pkg::cmd_t    cmd_i,
  input  logic [1:0]        layer_i,
  input  logic [2:0]        row_index_i,
  input  logic [7:0]        row_bits_i,
  input  logic [15:0]       amount_i,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  output logic [7:0]        row_select_o,
  output logic [7:0]        column_drive_o,
  output logic              overlay_shown_o
);

  localparam int RW = llms_pkg::ROW_W;
  localparam logic [RW-1:0] LAST_ROW = RW'(llms_pkg::ROWS - 1);

  logic [7:0]    front_q   [llms_pkg::ROWS];
  logic [7:0]    back_q    [llms_pkg::ROWS];
  logic [7:0]    overlay_q [llms_pkg::ROWS];
  logic [7:0]    popup_rows [llms_pkg::ROWS];
  logic [2:0]    phase_q;
  logic [RW-1:0] front_row_q, full_row_q, row_sel;
  logic [15:0]   timer_q, popup_dur_q;
  logic [3:0]    fg_slots_q;
  logic          shown, front_slot, row_ok;
  logic [7:0]    cols;
  logic [7:0]    n;

  assign shown      = (timer_q != 16'd0);
  assign front_slot = ({1'b0, phase_q} < fg_slots_q);
  assign row_sel    = front_slot ? front_row_q : full_row_q;
  assign row_ok     = ({1'b0, row_index_i} < 4'(llms_pkg::ROWS));
  assign n          = amount_i[7:0];

  always_comb begin
    if (front_slot) begin
      cols = shown ? overlay_q[row_sel] : front_q[row_sel];
    end else begin
      cols = front_q[row_sel] | back_q[row_sel] | (shown ? overlay_q[row_sel] : 8'h00);
    end
  end

  // Bar graph: row i lights n - 8i columns, clamped to 0..8.
  always_comb begin
    for (int i = 0; i < llms_pkg::ROWS; i++) begin
      logic [7:0] base;
      logic [7:0] lit;
      base = 8'(i * 8);
      lit  = (n > base) ? (n - base) : 8'd0;
      if (lit >= 8'd8) popup_rows[i] = 8'hff;
      else             popup_rows[i] = 8'((9'd1 << lit[2:0]) - 9'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      popup_dur_q <= llms_pkg::POPUP_DURATION_RST;
      fg_slots_q  <= llms_pkg::FOREGROUND_SLOTS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        llms_pkg::CFG_POPUP_DURATION:   popup_dur_q <= cfg_data_i;
        llms_pkg::CFG_FOREGROUND_SLOTS: fg_slots_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      front_row_q <= '0;
      full_row_q  <= '0;
      timer_q     <= '0;
      for (int i = 0; i < llms_pkg::ROWS; i++) begin
        front_q[i]   <= '0;
        back_q[i]    <= '0;
        overlay_q[i] <= '0;
      end
    end else begin
      if (cmd_i.tick) begin
        if (front_slot) front_row_q <= (front_row_q == LAST_ROW) ? '0 : front_row_q + 1'b1;
        else            full_row_q  <= (full_row_q == LAST_ROW) ? '0 : full_row_q + 1'b1;
        if (phase_q == 3'd0 && shown) timer_q <= timer_q - 16'd1;
        phase_q <= phase_q + 3'd1;
      end
      if (cmd_i.write_row && row_ok) begin
        case (layer_i)
          llms_pkg::LAYER_FRONT:   front_q[row_index_i[RW-1:0]]   <= row_bits_i;
          llms_pkg::LAYER_BACK:    back_q[row_index_i[RW-1:0]]    <= row_bits_i;
          llms_pkg::LAYER_OVERLAY: overlay_q[row_index_i[RW-1:0]] <= row_bits_i;
          default: ;
        endcase
      end
      if (cmd_i.clear_layer) begin
        for (int i = 0; i < llms_pkg::ROWS; i++) begin
          case (layer_i)
            llms_pkg::LAYER_FRONT:   front_q[i]   <= '0;
            llms_pkg::LAYER_BACK:    back_q[i]    <= '0;
            llms_pkg::LAYER_OVERLAY: overlay_q[i] <= '0;
            default: ;
          endcase
        end
      end
      if (cmd_i.set_timer) timer_q <= amount_i;
      if (cmd_i.popup) begin
        timer_q <= popup_dur_q;
        for (int i = 0; i < llms_pkg::ROWS; i++) overlay_q[i] <= popup_rows[i];
      end
    end
  end

  // Output register, loaded only by a tick
  always_ff @(posedge clk_i) begin
    if (cmd_i.tick) begin
      row_select_o    <= 8'(8'h80 >> row_sel);
      column_drive_o  <= cols;
      overlay_shown_o <= shown;
    end
  end

endmodule

// ===== rtl/core/layered_led_matrix_scanner_top.sv =====
// Layered LED matrix scanner: top level joining controller and datapath.
// A tick item yields its row item in the cycle after acceptance.
// Throughput: one item per cycle while the receiver takes row items; the single
//   output register is refilled in the cycle it is drained. Non-tick items produce no item.
// Reset (rst_ni, async, active low): empty output, stores, counters and timer
//   zero, popup_duration 500, foreground_slots 6.
module layered_led_matrix_scanner_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  operation_i,
  input  logic [1:0]  layer_i,
  input  logic [2:0]  row_index_i,
  input  logic [7:0]  row_bits_i,
  input  logic [15:0] amount_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  row_select_o,
  output logic [7:0]  column_drive_o,
  output logic        overlay_shown_o,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  llms_pkg::cmd_t cmd;

  // Controller owns the handshake and decodes each accepted item into a command.
  llms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Datapath holds the three row stores, scan state, timer and output register.
  llms_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .layer_i         (layer_i),
    .row_index_i     (row_index_i),
    .row_bits_i      (row_bits_i),
    .amount_i        (amount_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .row_select_o    (row_select_o),
    .column_drive_o  (column_drive_o),
    .overlay_shown_o (overlay_shown_o)
  );

  // A tick always produces an item in the next cycle.
  a_tick_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (operation_i == llms_pkg::OP_TICK) |=> out_valid_o)
    else $error("tick item did not produce a row item");

  // Other operations never invent an item.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !(in_valid_i && in_ready_o && (operation_i == llms_pkg::OP_TICK))
    |=> !out_valid_o)
    else $error("row item appeared without a tick");

  // A shown row drives exactly one row line.
  a_row_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot(row_select_o))
    else $error("row select not one-hot");

endmodule

// ===== tb/tb_layered_led_matrix_scanner_top.sv =====
// Testbench for the layered LED matrix scanner: scoreboard predictor, stimulus and checks.
`timescale 1ns / 1ps

module tb_layered_led_matrix_scanner_top;
  import llms_pkg::*;

  // Operation and layer codes the block must ignore.
  localparam logic [2:0] OP_SPARE_LO  = 3'd5;
  localparam logic [2:0] OP_SPARE_MID = 3'd6;
  localparam logic [2:0] OP_SPARE_HI  = 3'd7;
  localparam logic [1:0] LAYER_NONE   = 2'd3;

  localparam int HOLD_CYCLES  = 40;  // long receiver hold-off to back up the block
  localparam int PHASE_ITEMS  = 75;  // random items per configuration phase
  localparam int REPORT_LIMIT = 10;

  // One row item as the block presents it.
  typedef struct packed {
    logic [7:0] row_select;
    logic [7:0] column_drive;
    logic       overlay_shown;
  } scan_row_t;

  // Scoreboard: tracks the scanner state on every accepted item and holds the
  // row items each tick should produce, oldest first.
  class led_scan_checker;
    logic [15:0] pop_len;
    logic [3:0]  fg_slots;
    logic [2:0]  phase;
    logic [2:0]  fg_row;
    logic [2:0]  mix_row;
    logic [7:0]  fg_rows [ROWS];
    logic [7:0]  bg_rows [ROWS];
    logic [7:0]  ov_rows [ROWS];
    logic [15:0] ov_timer;
    scan_row_t   rows_due [$];
    int          failures;
    int          reported;

    function new();
      pop_len  = POPUP_DURATION_RST;
      fg_slots = FOREGROUND_SLOTS_RST;
      phase    = '0;
      fg_row   = '0;
      mix_row  = '0;
      ov_timer = '0;
      for (int i = 0; i < ROWS; i++) begin
        fg_rows[i] = '0;
        bg_rows[i] = '0;
        ov_rows[i] = '0;
      end
      failures = 0;
      reported = 0;
    endfunction

    function logic [2:0] advance_row(logic [2:0] r);
      return (int'(r) + 1 >= ROWS) ? 3'd0 : r + 3'd1;
    endfunction

    function void set_register(logic idx, logic [15:0] data);
      if (idx == CFG_POPUP_DURATION) pop_len = data;
      else fg_slots = data[3:0];
    endfunction

    function int pending();
      return rows_due.size();
    endfunction

    function void note_item(logic [2:0] op, logic [1:0] layer, logic [2:0] row,
                            logic [7:0] bits, logic [15:0] amount);
      scan_row_t  r;
      logic       shown;
      logic [2:0] sel;
      logic [7:0] cols;
      int         lit;
      case (op)
        OP_TICK: begin
          shown = (ov_timer != 0);
          if ({1'b0, phase} < fg_slots) begin
            // foreground slot: overlay replaces the foreground while it runs
            sel    = fg_row;
            cols   = shown ? ov_rows[sel] : fg_rows[sel];
            fg_row = advance_row(fg_row);
          end else begin
            sel  = mix_row;
            cols = fg_rows[sel] | bg_rows[sel];
            if (shown) cols = cols | ov_rows[sel];
            mix_row = advance_row(mix_row);
          end
          // timer decrements when the phase counter is zero, after the row is shown
          if (phase == 3'd0 && ov_timer != 0) ov_timer = ov_timer - 16'd1;
          phase = phase + 3'd1;
          r.row_select    = 8'h80 >> sel;
          r.column_drive  = cols;
          r.overlay_shown = shown;
          rows_due.push_back(r);
        end
        OP_WRITE_ROW: begin
          if (int'(row) < ROWS) begin
            case (layer)
              LAYER_FRONT:   fg_rows[row] = bits;
              LAYER_BACK:    bg_rows[row] = bits;
              LAYER_OVERLAY: ov_rows[row] = bits;
              default: ;
            endcase
          end
        end
        OP_CLEAR: begin
          for (int i = 0; i < ROWS; i++) begin
            case (layer)
              LAYER_FRONT:   fg_rows[i] = '0;
              LAYER_BACK:    bg_rows[i] = '0;
              LAYER_OVERLAY: ov_rows[i] = '0;
              default: ;
            endcase
          end
        end
        OP_SET_TIMER: ov_timer = amount;
        OP_POPUP: begin
          // bar graph: each row takes up to eight of the number's columns
          for (int i = 0; i < ROWS; i++) begin
            lit = int'(amount[7:0]) - 8 * i;
            if (lit < 0) lit = 0;
            ov_rows[i] = (lit >= 8) ? 8'hff : (8'hff >> (8 - lit));
          end
          ov_timer = pop_len;
        end
        default: ;
      endcase
    endfunction

    function void check_row(logic [7:0] sel, logic [7:0] cols, logic shown);
      scan_row_t e;
      if (rows_due.size() == 0) begin
        failures++;
        if (reported < REPORT_LIMIT) begin
          reported++;
          $display("%0t: unexpected row item sel=%h cols=%h shown=%b",
                   $realtime, sel, cols, shown);
        end
        return;
      end
      e = rows_due.pop_front();
      if (e.row_select !== sel || e.column_drive !== cols || e.overlay_shown !== shown) begin
        failures++;
        if (reported < REPORT_LIMIT) begin
          reported++;
          $display("%0t: row item mismatch sel exp=%h got=%h cols exp=%h got=%h shown exp=%b got=%b",
                   $realtime, e.row_select, sel, e.column_drive, cols, e.overlay_shown, shown);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  operation_i;
  logic [1:0]  layer_i;
  logic [2:0]  row_index_i;
  logic [7:0]  row_bits_i;
  logic [15:0] amount_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  row_select_o;
  logic [7:0]  column_drive_o;
  logic        overlay_shown_o;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [15:0] cfg_data_i;

  led_scan_checker scan;

  // Shared between stimulus and the receiver process.
  bit steady;    // no idling on either side while set
  bit hold_req;  // asks the receiver for one long hold-off

  layered_led_matrix_scanner_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .layer_i         (layer_i),
    .row_index_i     (row_index_i),
    .row_bits_i      (row_bits_i),
    .amount_i        (amount_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .row_select_o    (row_select_o),
    .column_drive_o  (column_drive_o),
    .overlay_shown_o (overlay_shown_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Offer one item from the falling edge and hold it until accepted. Valid is
  // left high on return so back-to-back items never drop it.
  task automatic send_item(input logic [2:0] op, input logic [1:0] layer,
                           input logic [2:0] row, input logic [7:0] bits,
                           input logic [15:0] amount);
    in_valid_i  <= 1'b1;
    operation_i <= op;
    layer_i     <= layer;
    row_index_i <= row;
    row_bits_i  <= bits;
    amount_i    <= amount;
    do @(posedge clk_i); while (!in_ready_o);
    scan.note_item(op, layer, row, bits, amount);
    @(negedge clk_i);
  endtask

  // Sender gap: about 8 in a hundred items are followed by a gap with valid low.
  task automatic sender_gap();
    if (!steady && $urandom_range(0, 99) < 8) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  // Random item mix: mostly ticks and row writes, some timer and popup traffic,
  // a few ignored codes. Timer loads are mostly short so the overlay switches
  // on and off often and the timer sits at zero for a while.
  task automatic send_random();
    int          pick;
    logic [2:0]  op;
    logic [1:0]  layer;
    logic [15:0] amount;
    pick   = $urandom_range(0, 99);
    layer  = ($urandom_range(0, 9) == 0) ? LAYER_NONE : 2'($urandom_range(0, 2));
    amount = 16'($urandom);
    if (pick < 45) op = OP_TICK;
    else if (pick < 70) op = OP_WRITE_ROW;
    else if (pick < 75) op = OP_CLEAR;
    else if (pick < 84) begin
      op = OP_SET_TIMER;
      if ($urandom_range(0, 9) < 7) amount = 16'($urandom_range(0, 12));
    end else if (pick < 92) op = OP_POPUP;
    else op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    send_item(op, layer, 3'($urandom), 8'($urandom), amount);
    sender_gap();
  endtask

  // Bring the block to idle: drop valid and wait until every row item is back.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (scan.pending() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_register(input logic idx, input logic [15:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    scan.set_register(idx, data);
    @(negedge clk_i);
  endtask

  // Receiver: random stalls, none while steady, and one long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_ready_i <= 1'b0;
      end else if (steady) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= 8);
      end
    end
  end

  // Row items are checked as they are accepted.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      scan.check_row(row_select_o, column_drive_o, overlay_shown_o);
  end

  initial begin
    logic [15:0] durations [6];
    logic [15:0] slots [6];
    durations = '{16'd0, 16'd65535, 16'd3, 16'd1, 16'd2, 16'd500};
    slots     = '{16'd0, 16'd8, 16'd1, 16'd7, 16'd3, 16'd6};
    scan        = new();
    steady      = 1'b0;
    hold_req    = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    operation_i = OP_TICK;
    layer_i     = LAYER_FRONT;
    row_index_i = '0;
    row_bits_i  = '0;
    amount_i    = '0;
    out_ready_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_POPUP_DURATION;
    cfg_data_i  = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part under reset settings (popup 500, six foreground slots).
    send_item(OP_TICK, LAYER_FRONT, 3'd0, 8'h00, 16'h0000);         // all empty
    send_item(OP_WRITE_ROW, LAYER_FRONT, 3'd0, 8'h01, 16'h0000);
    send_item(OP_WRITE_ROW, LAYER_BACK, 3'd7, 8'hff, 16'hffff);
    send_item(OP_WRITE_ROW, LAYER_OVERLAY, 3'd3, 8'ha5, 16'h0000);
    send_item(OP_WRITE_ROW, LAYER_NONE, 3'd2, 8'hff, 16'h0000);     // no such layer
    send_item(OP_SET_TIMER, LAYER_FRONT, 3'd0, 8'h00, 16'hffff);    // longest timer
    send_item(OP_TICK, LAYER_FRONT, 3'd0, 8'h00, 16'h0000);
    send_item(OP_POPUP, LAYER_FRONT, 3'd0, 8'h00, 16'h00ff);        // all rows full
    send_item(OP_POPUP, LAYER_BACK, 3'd0, 8'h00, 16'h0000);         // empty bar
    send_item(OP_POPUP, LAYER_NONE, 3'd0, 8'h00, 16'hff13);         // partial row, layer ignored
    send_item(OP_TICK, LAYER_FRONT, 3'd0, 8'h00, 16'h0000);
    send_item(OP_CLEAR, LAYER_NONE, 3'd0, 8'h00, 16'h0000);         // no such layer
    send_item(OP_CLEAR, LAYER_OVERLAY, 3'd0, 8'h00, 16'h0000);
    send_item(OP_TICK, LAYER_FRONT, 3'd0, 8'h00, 16'h0000);
    send_item(OP_CLEAR, LAYER_BACK, 3'd0, 8'h00, 16'h0000);
    send_item(OP_CLEAR, LAYER_FRONT, 3'd0, 8'h00, 16'h0000);
    send_item(OP_SPARE_LO, LAYER_BACK, 3'd7, 8'hff, 16'hffff);       // ignored codes
    send_item(OP_SPARE_MID, LAYER_OVERLAY, 3'd5, 8'h5a, 16'h1234);
    send_item(OP_SPARE_HI, LAYER_NONE, 3'd0, 8'h00, 16'h0000);
    send_item(OP_SET_TIMER, LAYER_FRONT, 3'd0, 8'h00, 16'h0001);    // runs out, stays at zero
    repeat (6) send_item(OP_TICK, LAYER_FRONT, 3'd0, 8'h00, 16'h0000);
    wait_idle();

    // Random phases, each under its own register settings, the extremes
    // included. Phase 1 carries the long receiver hold-off, phase 4 runs
    // without any idling on either side.
    for (int p = 0; p < 6; p++) begin
      write_register(CFG_POPUP_DURATION, durations[p]);
      write_register(CFG_FOREGROUND_SLOTS, slots[p]);
      steady = (p == 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 1 && n == 10) hold_req = 1'b1;
        send_random();
      end
      wait_idle();
      steady = 1'b0;
    end

    repeat (5) @(posedge clk_i);
    if (scan.failures == 0 && scan.pending() == 0) begin
      $display("tb_layered_led_matrix_scanner_top: done, clean");
    end else begin
      $display("tb_layered_led_matrix_scanner_top: done, errors");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("tb_layered_led_matrix_scanner_top: done, errors");
    $finish;
  end

endmodule
